[hdl/pst_pkg.sv]
// Shared types and constants for the periodic task slot timer.
// Used by pst_table, pst_seq and periodic_task_slot_timer; depends on nothing.
`timescale 1ns / 1ps

package pst_pkg;

  localparam int SLOTS       = 8;
  localparam int MAX_RESULTS = 8;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_DEL  = 2'd1,
    KIND_TICK = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    RK_ADD  = 2'd0,
    RK_DEL  = 2'd1,
    RK_FIRE = 2'd2
  } rkind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic        en;
    logic        busy;
    logic [7:0]  tid;
    logic [31:0] period;
    logic [31:0] count;
  } slot_wr_t;

  typedef struct packed {
    logic        busy;
    logic [7:0]  tid;
    logic [31:0] period;
    logic [31:0] count_inc;
    logic        fire;
  } slot_rd_t;

  typedef struct packed {
    logic        valid;
    rkind_t      result_kind;
    status_t     status;
    logic [2:0]  slot_index;
    logic [7:0]  fired_id;
    logic        last;
  } result_t;

endpackage

[hdl/pst_table.sv]
// Slot table: occupied marks, task ids, periods and tick counters, with the
// shared 32-bit increment and period compare for the addressed slot. Uses pst_pkg.
`timescale 1ns / 1ps

module pst_table import pst_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  idx_t     idx,
  input  slot_wr_t wr,
  output slot_rd_t rd
);

  logic [SLOTS-1:0] busy;
  logic [7:0]       tid    [SLOTS];
  logic [31:0]      period [SLOTS];
  logic [31:0]      count  [SLOTS];

  always_comb begin
    rd.busy      = busy[idx];
    rd.tid       = tid[idx];
    rd.period    = period[idx];
    rd.count_inc = count[idx] + 32'd1;
    rd.fire      = (period[idx] != 32'd0) && (rd.count_inc >= period[idx]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        tid[i]   <= 8'd0;
        count[i] <= 32'd0;
      end
    end else if (wr.en) begin
      busy[idx]  <= wr.busy;
      tid[idx]   <= wr.tid;
      count[idx] <= wr.count;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      period[idx] <= wr.period;
    end
  end

endmodule

[hdl/pst_seq.sv]
// Sequencer that walks the slot table one slot per cycle while out_free allows it,
// for add, delete and tick requests, and holds the pending fire result. Uses pst_pkg.
`timescale 1ns / 1ps

module pst_seq import pst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_tid,
  input  logic [31:0] in_period,
  input  logic        out_free,
  output idx_t        idx,
  output slot_wr_t    wr,
  input  slot_rd_t    rd,
  output result_t     emit
);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_t;

  state_t           state;
  kind_t            op;
  logic [7:0]       req_tid;
  logic [31:0]      req_period;
  result_t          pend;
  logic [CNT_W-1:0] nfire;

  logic last_slot;
  logic advance;
  logic finish;
  logic walk_end;
  logic record;

  assign in_ready  = (state == S_IDLE);
  assign last_slot = (idx == idx_t'(SLOTS - 1));

  always_comb begin
    wr       = '0;
    emit     = '0;
    advance  = 1'b0;
    finish   = 1'b0;
    walk_end = 1'b0;
    record   = 1'b0;
    case (state)
      S_WALK: begin
        case (op)
          KIND_ADD: begin
            if (!rd.busy) begin
              if (out_free) begin
                wr     = '{en: 1'b1, busy: 1'b1, tid: req_tid, period: req_period,
                           count: 32'd0};
                emit   = '{valid: 1'b1, result_kind: RK_ADD, status: ST_OK,
                           slot_index: 3'(idx), fired_id: req_tid, last: 1'b1};
                finish = 1'b1;
              end
            end else if (last_slot) begin
              if (out_free) begin
                emit   = '{valid: 1'b1, result_kind: RK_ADD, status: ST_FULL,
                           slot_index: 3'd0, fired_id: req_tid, last: 1'b1};
                finish = 1'b1;
              end
            end else begin
              advance = 1'b1;
            end
          end
          KIND_DEL: begin
            if (rd.busy && (rd.tid == req_tid)) begin
              if (out_free) begin
                wr     = '{en: 1'b1, busy: 1'b0, tid: 8'd0, period: 32'd0,
                           count: 32'd0};
                emit   = '{valid: 1'b1, result_kind: RK_DEL, status: ST_OK,
                           slot_index: 3'(idx), fired_id: req_tid, last: 1'b1};
                finish = 1'b1;
              end
            end else if (last_slot) begin
              if (out_free) begin
                emit   = '{valid: 1'b1, result_kind: RK_DEL, status: ST_NOTFOUND,
                           slot_index: 3'd0, fired_id: req_tid, last: 1'b1};
                finish = 1'b1;
              end
            end else begin
              advance = 1'b1;
            end
          end
          default: begin
            // A new firing pushes the previous one out, so the final one can be marked last.
            if (!(rd.busy && rd.fire && (nfire < CNT_W'(MAX_RESULTS)) && pend.valid
                  && !out_free)) begin
              if (rd.busy) begin
                wr = '{en: 1'b1, busy: 1'b1, tid: rd.tid, period: rd.period,
                       count: rd.fire ? 32'd0 : rd.count_inc};
              end
              record = rd.busy && rd.fire && (nfire < CNT_W'(MAX_RESULTS));
              if (record && pend.valid) begin
                emit = pend;
              end
              if (last_slot) begin
                walk_end = 1'b1;
              end else begin
                advance = 1'b1;
              end
            end
          end
        endcase
      end
      S_DONE: begin
        if (pend.valid && out_free) begin
          emit      = pend;
          emit.last = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend.valid <= 1'b0;
      nfire      <= '0;
      idx        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op         <= kind_t'(in_kind);
            req_tid    <= in_tid;
            req_period <= in_period;
            idx        <= '0;
            nfire      <= '0;
            pend.valid <= 1'b0;
            if (in_kind inside {KIND_ADD, KIND_DEL, KIND_TICK}) begin
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (finish) begin
            state <= S_IDLE;
          end else if (walk_end) begin
            state <= S_DONE;
          end
          if (advance) begin
            idx <= idx + idx_t'(1);
          end
          if (record) begin
            pend  <= '{valid: 1'b1, result_kind: RK_FIRE, status: ST_OK,
                       slot_index: 3'(idx), fired_id: rd.tid, last: 1'b0};
            nfire <= nfire + CNT_W'(1);
          end
        end
        S_DONE: begin
          if (!pend.valid || out_free) begin
            pend.valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/periodic_task_slot_timer.sv]
// Top level of the periodic task slot timer: stream ports and output register.
// Instantiates pst_table and pst_seq; uses pst_pkg.
`timescale 1ns / 1ps

// The block keeps a table of SLOTS task slots and takes one request beat at
// a time. Every request walks the table one slot per cycle through a single
// 32-bit increment and compare unit, stalling while a due result waits on
// m_tready; an add or delete stops at the slot it settles on or at the last
// slot, and a tick visits every slot. A tick emits one beat per firing slot
// in slot order with the final beat marked by tlast; a tick with no firing
// slot emits nothing. No clearing pass is needed after reset.

module periodic_task_slot_timer import pst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // kind
  input  logic [39:0] s_tdata,   // task_id[7:0], period[39:8]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [1:0]  m_tuser,   // result_kind
  output logic [15:0] m_tdata,   // status[1:0], slot_index[4:2], fired_id[12:5], zeros
  output logic        m_tlast
);

  idx_t     idx;
  slot_wr_t wr;
  slot_rd_t rd;
  result_t  emit;
  logic     out_free;

  assign out_free = !m_tvalid || m_tready;

  pst_table u_table (
    .clk (clk),
    .rst (rst),
    .idx (idx),
    .wr  (wr),
    .rd  (rd)
  );

  pst_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_kind   (s_tuser),
    .in_tid    (s_tdata[7:0]),
    .in_period (s_tdata[39:8]),
    .out_free  (out_free),
    .idx       (idx),
    .wr        (wr),
    .rd        (rd),
    .emit      (emit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      m_tuser <= emit.result_kind;
      m_tdata <= {3'b000, emit.fired_id, emit.slot_index, emit.status};
      m_tlast <= emit.last;
    end
  end

endmodule
